// ----- sv/best_fit_size_class_allocator_unit_assert.svh -----
// Assertion macros for the allocator. Synthesis sees empty bodies.
`ifndef BEST_FIT_SIZE_CLASS_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_SIZE_CLASS_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under the reset.
`define BFSCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication under the reset.
`define BFSCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BFSCA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BFSCA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/bfsca_pkg.sv -----
`timescale 1ns / 1ps

package bfsca_pkg;

	localparam int FREE_ENTRIES = 16;
	localparam int USED_ENTRIES = 16;
	localparam int ADDR_BITS    = 16;

	// Fixed field widths of the channels
	localparam int CMD_W    = 1;
	localparam int REQ_IN_W = 16;
	localparam int CHUNK_W  = 16;
	localparam int BADDR_W  = 16;
	localparam int SIZE_W   = 10;
	localparam int STATUS_W = 3;
	localparam int HEAP_W   = 17;

	localparam int CLS_W = 3;
	localparam int REQ_W = 10;

	localparam int FREE_IW = $clog2(FREE_ENTRIES);
	localparam int USED_IW = $clog2(USED_ENTRIES);
	localparam int FREE_CW = $clog2(FREE_ENTRIES + 1);
	localparam int USED_CW = $clog2(USED_ENTRIES + 1);
	localparam int CNT_W   = (FREE_CW > USED_CW) ? FREE_CW : USED_CW;
	localparam int LIM_W   = (ADDR_BITS + 1 > HEAP_W) ? ADDR_BITS + 1 : HEAP_W;
	localparam int ADDR_XW = (ADDR_BITS > BADDR_W) ? ADDR_BITS : BADDR_W;

	localparam int FREE_W = ADDR_BITS + CLS_W;
	localparam int USED_W = ADDR_BITS + CLS_W + REQ_W;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_DEALLOC = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic                 dealloc;
		logic [CLS_W-1:0]     ent_class;
		logic [CLS_W-1:0]     need_class;
		logic [CLS_W-1:0]     best_class;
		logic                 have_best;
		logic [ADDR_BITS-1:0] ent_addr;
		logic [ADDR_BITS-1:0] key;
	} cmp_req_t;

	typedef struct packed {
		logic take;
	} cmp_rsp_t;

endpackage

// ----- sv/bfsca_if.sv -----
`timescale 1ns / 1ps

interface bfsca_req_if import bfsca_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [REQ_IN_W-1:0] request_size;
	logic [CHUNK_W-1:0]  chunk_address;

	modport source (output valid, cmd, request_size, chunk_address, input ready);
	modport sink (input valid, cmd, request_size, chunk_address, output ready);
endinterface

interface bfsca_rsp_if import bfsca_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BADDR_W-1:0]  block_address;
	logic [SIZE_W-1:0]   block_size;
	logic                reused;
	logic [STATUS_W-1:0] status;

	modport source (output valid, block_address, block_size, reused, status, input ready);
	modport sink (input valid, block_address, block_size, reused, status, output ready);
endinterface

// ----- sv/bfsca_ram.sv -----
`timescale 1ns / 1ps

module bfsca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/bfsca_cmp.sv -----
`timescale 1ns / 1ps

module bfsca_cmp import bfsca_pkg::*; (
	input  cmp_req_t cmp_req,
	output cmp_rsp_t cmp_rsp
);

	logic fits;
	logic better;
	logic match;

	// best fit: large enough, and strictly smaller than the best so far
	assign fits   = cmp_req.ent_class >= cmp_req.need_class;
	assign better = !cmp_req.have_best || (cmp_req.ent_class < cmp_req.best_class);
	assign match  = cmp_req.ent_addr == cmp_req.key;

	assign cmp_rsp.take = cmp_req.dealloc ? match : (fits && better);

endmodule

// ----- sv/best_fit_size_class_allocator_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                                     Handshake
// request   in   cmd, request_size, chunk_address            valid/ready
// result    out  block_address, block_size, reused, status   valid/ready
// cfg       in   cfg_wdata (heap_limit)                      cfg_we, no wait
//
// One word at a time; request.ready is high only in idle. An oversized or used-full allocate
// goes from accept straight to finish. Other words pass accept, scan, decide, compaction
// (only when an entry moves between stores) and finish in that order; a release scan stops
// at its first hit, and compaction closes the gap behind the taken entry. Each store has one
// registered read port.
// Reset clears counts and bump pointer, loads heap_limit 65536; finish holds while a word waits.

`include "best_fit_size_class_allocator_unit_assert.svh"

module best_fit_size_class_allocator_unit import bfsca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [HEAP_W-1:0] cfg_wdata,
	bfsca_req_if.sink         request,
	bfsca_rsp_if.source       result
);

	localparam int MIN_BLOCK   = 32;
	localparam int MAX_REQ     = 512;
	localparam int NUM_CLASSES = 5;
	localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_SCAN    = 5'b00010,
		S_DECIDE  = 5'b00100,
		S_COMPACT = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

	// size class code to bytes
	function automatic logic [SIZE_W-1:0] class_size(input logic [CLS_W-1:0] c);
		class_size = SIZE_W'(MIN_BLOCK) << c;
	endfunction

	// smallest class that holds r; only meaningful for r up to MAX_REQ
	function automatic logic [CLS_W-1:0] round_class(input logic [REQ_IN_W-1:0] r);
		logic [CLS_W-1:0] c;
		c = CLS_W'(NUM_CLASSES - 1);
		for (int k = NUM_CLASSES - 2; k >= 0; k--) begin
			if (r <= REQ_IN_W'(MIN_BLOCK << k)) begin
				c = CLS_W'(k);
			end
		end
		return c;
	endfunction

	function automatic logic [ADDR_BITS-1:0] to_key(input logic [CHUNK_W-1:0] a);
		logic [ADDR_XW-1:0] x;
		x = ADDR_XW'(a);
		return x[ADDR_BITS-1:0];
	endfunction

	function automatic logic [BADDR_W-1:0] to_port(input logic [ADDR_BITS-1:0] a);
		logic [ADDR_XW-1:0] x;
		x = ADDR_XW'(a);
		return x[BADDR_W-1:0];
	endfunction

	// control state
	state_t              state_q;
	logic [HEAP_W-1:0]   heap_limit_q;
	logic [FREE_CW-1:0]  free_count_q;
	logic [USED_CW-1:0]  used_count_q;
	logic [LIM_W-1:0]    bump_q;
	logic [CNT_W-1:0]    idx_q;
	logic                rd_v_s1;
	logic                have_q;
	logic                out_valid_q;

	// datapath
	logic                 cmd_q;
	logic [REQ_W-1:0]     req_q;
	logic [CLS_W-1:0]     cls_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [CNT_W-1:0]     rd_idx_s1;
	logic [CNT_W-1:0]     best_idx_q;
	logic [CLS_W-1:0]     best_cls_q;
	logic [ADDR_BITS-1:0] best_addr_q;
	logic [BADDR_W-1:0]   res_addr_q;
	logic [SIZE_W-1:0]    res_size_q;
	logic                 res_reused_q;
	status_t              res_status_q;
	logic [BADDR_W-1:0]   out_addr_q;
	logic [SIZE_W-1:0]    out_size_q;
	logic                 out_reused_q;
	status_t              out_status_q;

	// store ports
	logic                 free_we;
	logic [FREE_IW-1:0]   free_waddr;
	logic [FREE_W-1:0]    free_wdata;
	logic [FREE_W-1:0]    free_rd;
	logic                 used_we;
	logic [USED_IW-1:0]   used_waddr;
	logic [USED_W-1:0]    used_wdata;
	logic [USED_W-1:0]    used_rd;

	logic                 in_fire;
	logic                 too_big;
	logic                 used_full;
	logic                 free_full;
	logic [CNT_W-1:0]     store_cnt;
	logic                 scan_issue;
	logic                 compact_issue;
	logic                 rd_go;
	logic                 scan_done;
	logic                 compact_done;
	logic                 take_en;
	logic [CNT_W-1:0]     move_addr;
	logic [ADDR_BITS-1:0] ent_addr;
	logic [CLS_W-1:0]     ent_cls;
	logic [LIM_W-1:0]     cap;
	logic [LIM_W-1:0]     heap_ext;
	logic [LIM_W-1:0]     limit;
	logic [LIM_W-1:0]     need;
	logic                 bump_ok;
	logic                 out_slot_free;
	cmp_req_t             cmp_req;
	cmp_rsp_t             cmp_rsp;

	// handshake
	assign request.ready = (state_q == S_IDLE);
	assign in_fire       = request.valid && request.ready;
	assign out_slot_free = !out_valid_q || result.ready;

	assign result.valid         = out_valid_q;
	assign result.block_address = out_addr_q;
	assign result.block_size    = out_size_q;
	assign result.reused        = out_reused_q;
	assign result.status        = out_status_q;

	assign too_big   = request.request_size > REQ_IN_W'(MAX_REQ);
	assign used_full = used_count_q >= USED_CW'(USED_ENTRIES);
	assign free_full = free_count_q >= FREE_CW'(FREE_ENTRIES);

	// allocate walks the free store, deallocate the used store; the
	// compaction then works on the same store
	assign store_cnt = cmd_q ? CNT_W'(used_count_q) : CNT_W'(free_count_q);

	// a release stops at the first hit
	assign scan_issue    = (state_q == S_SCAN) && (idx_q < store_cnt) && !(cmd_q && have_q);
	assign compact_issue = (state_q == S_COMPACT) && (idx_q < store_cnt);
	assign rd_go         = scan_issue || compact_issue;
	assign scan_done     = (state_q == S_SCAN) && !scan_issue && !rd_v_s1;
	assign compact_done  = (state_q == S_COMPACT) && !compact_issue && !rd_v_s1;
	assign move_addr     = rd_idx_s1 - 1'b1;

	assign ent_addr = cmd_q ? used_rd[USED_W-1 -: ADDR_BITS] : free_rd[FREE_W-1 -: ADDR_BITS];
	assign ent_cls  = cmd_q ? used_rd[REQ_W +: CLS_W] : free_rd[CLS_W-1:0];

	assign cmp_req.dealloc    = cmd_q;
	assign cmp_req.ent_class  = ent_cls;
	assign cmp_req.need_class = cls_q;
	assign cmp_req.best_class = best_cls_q;
	assign cmp_req.have_best  = have_q;
	assign cmp_req.ent_addr   = ent_addr;
	assign cmp_req.key        = key_q;

	bfsca_cmp u_cmp (
		.cmp_req (cmp_req),
		.cmp_rsp (cmp_rsp)
	);

	assign take_en = (state_q == S_SCAN) && rd_v_s1 && cmp_rsp.take && !(cmd_q && have_q);

	// bump limit: the smaller of heap_limit and the address space
	assign cap      = LIM_W'(1) << ADDR_BITS;
	assign heap_ext = LIM_W'(heap_limit_q);
	assign limit    = (heap_ext < cap) ? heap_ext : cap;
	assign need     = LIM_W'(class_size(cls_q));
	assign bump_ok  = (bump_q <= limit) && ((limit - bump_q) >= need);

	// free store: push on release, shift down on reuse
	always_comb begin
		free_we    = ((state_q == S_DECIDE) && cmd_q && have_q && !free_full) ||
			((state_q == S_COMPACT) && rd_v_s1 && !cmd_q);
		free_waddr = (state_q == S_DECIDE) ? free_count_q[FREE_IW-1:0] : move_addr[FREE_IW-1:0];
		free_wdata = (state_q == S_DECIDE) ? {best_addr_q, best_cls_q} : free_rd;
	end

	// used store: push on grant, shift down on release
	always_comb begin
		used_we    = ((state_q == S_DECIDE) && !cmd_q && (have_q || bump_ok)) ||
			((state_q == S_COMPACT) && rd_v_s1 && cmd_q);
		used_waddr = (state_q == S_DECIDE) ? used_count_q[USED_IW-1:0] : move_addr[USED_IW-1:0];
		if (state_q == S_DECIDE) begin
			used_wdata = {(have_q ? best_addr_q : bump_q[ADDR_BITS-1:0]),
				(have_q ? best_cls_q : cls_q), req_q};
		end else begin
			used_wdata = used_rd;
		end
	end

	bfsca_ram #(.WIDTH(FREE_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (idx_q[FREE_IW-1:0]),
		.rdata (free_rd)
	);

	bfsca_ram #(.WIDTH(USED_W), .DEPTH(USED_ENTRIES)) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (idx_q[USED_IW-1:0]),
		.rdata (used_rd)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= HEAP_RESET;
			free_count_q <= '0;
			used_count_q <= '0;
			bump_q       <= '0;
			idx_q        <= '0;
			rd_v_s1      <= 1'b0;
			have_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_limit_q <= cfg_wdata;
			end
			// load the output register from finish, else drop the word once taken
			if ((state_q == S_FINISH) && out_slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			rd_v_s1 <= rd_go;
			if (rd_go) begin
				idx_q <= idx_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q  <= '0;
						have_q <= 1'b0;
						// drop an oversized or used-full allocate without a search
						if ((request.cmd == CMD_ALLOC) && (too_big || used_full)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (take_en) begin
						have_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (cmd_q == CMD_ALLOC) begin
						if (have_q) begin
							used_count_q <= used_count_q + 1'b1;
							idx_q        <= best_idx_q + 1'b1;
							state_q      <= S_COMPACT;
						end else begin
							if (bump_ok) begin
								used_count_q <= used_count_q + 1'b1;
								bump_q       <= bump_q + need;
							end
							state_q <= S_FINISH;
						end
					end else begin
						if (have_q && !free_full) begin
							free_count_q <= free_count_q + 1'b1;
							idx_q        <= best_idx_q + 1'b1;
							state_q      <= S_COMPACT;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_COMPACT: begin
					if (compact_done) begin
						if (cmd_q == CMD_DEALLOC) begin
							used_count_q <= used_count_q - 1'b1;
						end else begin
							free_count_q <= free_count_q - 1'b1;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rd_go) begin
			rd_idx_s1 <= idx_q;
		end
		if (take_en) begin
			best_idx_q  <= rd_idx_s1;
			best_cls_q  <= ent_cls;
			best_addr_q <= ent_addr;
		end
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd_q        <= request.cmd;
					req_q        <= request.request_size[REQ_W-1:0];
					cls_q        <= round_class(request.request_size);
					key_q        <= to_key(request.chunk_address);
					res_addr_q   <= '0;
					res_size_q   <= '0;
					res_reused_q <= 1'b0;
					res_status_q <= too_big ? ST_TOO_LARGE : ST_FULL;
				end
			end
			S_DECIDE: begin
				if (cmd_q == CMD_ALLOC) begin
					if (have_q) begin
						res_addr_q   <= to_port(best_addr_q);
						res_size_q   <= class_size(best_cls_q);
						res_reused_q <= 1'b1;
						res_status_q <= ST_DONE;
					end else if (bump_ok) begin
						res_addr_q   <= bump_q[BADDR_W-1:0];
						res_size_q   <= class_size(cls_q);
						res_status_q <= ST_DONE;
					end else begin
						res_status_q <= ST_EXHAUSTED;
					end
				end else begin
					if (!have_q) begin
						res_status_q <= ST_NOT_FOUND;
					end else if (free_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_addr_q   <= to_port(best_addr_q);
						res_size_q   <= class_size(best_cls_q);
						res_status_q <= ST_DONE;
					end
				end
			end
			S_FINISH: begin
				if (out_slot_free) begin
					out_addr_q   <= res_addr_q;
					out_size_q   <= res_size_q;
					out_reused_q <= res_reused_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// an accepted word always leaves idle in the cycle after it is accepted
	`BFSCA_ASSERT_NXT(a_accept_busy, clk, arst_n, in_fire, state_q != S_IDLE, "accept did not start work")
	// failures carry no block
	`BFSCA_ASSERT_IMP(a_fail_zero, clk, arst_n, out_valid_q && (out_status_q != ST_DONE), (out_addr_q == '0) && (out_size_q == '0) && !out_reused_q, "failure with payload")
	// a success names one size class
	`BFSCA_ASSERT_IMP(a_done_size, clk, arst_n, out_valid_q && (out_status_q == ST_DONE), $onehot(out_size_q) && (out_size_q >= SIZE_W'(MIN_BLOCK)), "bad block size")
	// every grant pushes one used entry
	`BFSCA_ASSERT_NXT(a_used_grow, clk, arst_n, (state_q == S_DECIDE) && (cmd_q == CMD_ALLOC) && (have_q || bump_ok), used_count_q == $past(used_count_q) + 1'b1, "grant without used push")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import bfsca_pkg::*;

	typedef struct packed {
		logic [BADDR_W-1:0]  block_address;
		logic [SIZE_W-1:0]   block_size;
		logic                reused;
		logic [STATUS_W-1:0] status;
	} grant_t;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HEAP_SPAN   = 1 << ADDR_BITS;
	// Blocks never vanish: keep used plus free below the point where both stores lock up
	localparam int BLOCK_CAP   = 28;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [HEAP_W-1:0] cfg_wdata;

	bfsca_req_if req_ch ();
	bfsca_rsp_if rsp_ch ();

	best_fit_size_class_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (req_ch),
		.result    (rsp_ch)
	);

	// Shadow of the allocator: both stores, counts, bump pointer and limit
	logic [ADDR_BITS-1:0] free_addr [FREE_ENTRIES];
	logic [CLS_W-1:0]     free_cls [FREE_ENTRIES];
	int                   free_n;
	logic [ADDR_BITS-1:0] used_addr [USED_ENTRIES];
	logic [CLS_W-1:0]     used_cls [USED_ENTRIES];
	int                   used_n;
	int                   bump;
	int                   heap_limit;

	grant_t pending_grants[$];
	int     error_count;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Drive every input to a known value before the first edge
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ALLOC;
		req_ch.request_size = '0;
		req_ch.chunk_address = '0;
		rsp_ch.ready = 1'b0;
		cycle_count = 0;
		error_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		free_n = 0;
		used_n = 0;
		bump = 0;
		heap_limit = HEAP_SPAN;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: end the run if the block stops answering
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d words still expected",
			cycle_count, pending_grants.size());
		$display("Verification failed");
		$finish;
	end

	// Work out the result of one accepted word and advance the shadow state
	function automatic grant_t apply_word(input logic c, input logic [15:0] sz,
			input logic [15:0] ad);
		grant_t g;
		int need;
		int best;
		int hit;
		int lim;
		int blk;
		int i;
		g = '0;
		need = 0;
		best = -1;
		hit = -1;
		if (c == CMD_ALLOC) begin
			if (sz > 16'd512) begin
				g.status = ST_TOO_LARGE;
				return g;
			end
			while ((32 << need) < sz) need++;
			// The used-store check comes after the size test, before any search
			if (used_n >= USED_ENTRIES) begin
				g.status = ST_FULL;
				return g;
			end
			// Smallest fitting class; strict compare keeps the earliest freed on a tie
			for (i = 0; i < free_n; i++) begin
				if (free_cls[i] >= need && (best < 0 || free_cls[i] < free_cls[best]))
					best = i;
			end
			if (best >= 0) begin
				g.block_address = free_addr[best];
				g.block_size = SIZE_W'(32 << free_cls[best]);
				g.reused = 1'b1;
				used_addr[used_n] = free_addr[best];
				used_cls[used_n] = free_cls[best];
				used_n++;
				for (i = best; i + 1 < free_n; i++) begin
					free_addr[i] = free_addr[i + 1];
					free_cls[i] = free_cls[i + 1];
				end
				free_n--;
				return g;
			end
			blk = 32 << need;
			lim = (heap_limit < HEAP_SPAN) ? heap_limit : HEAP_SPAN;
			// Bump may sit above a limit that was lowered later
			if (bump > lim || lim - bump < blk) begin
				g.status = ST_EXHAUSTED;
				return g;
			end
			used_addr[used_n] = ADDR_BITS'(bump);
			used_cls[used_n] = CLS_W'(need);
			used_n++;
			g.block_address = BADDR_W'(bump);
			g.block_size = SIZE_W'(blk);
			bump += blk;
			return g;
		end
		for (i = 0; i < used_n; i++) begin
			if (used_addr[i] == ad) begin
				hit = i;
				break;
			end
		end
		if (hit < 0) begin
			g.status = ST_NOT_FOUND;
			return g;
		end
		if (free_n >= FREE_ENTRIES) begin
			g.status = ST_FULL;
			return g;
		end
		g.block_address = used_addr[hit];
		g.block_size = SIZE_W'(32 << used_cls[hit]);
		free_addr[free_n] = used_addr[hit];
		free_cls[free_n] = used_cls[hit];
		free_n++;
		for (i = hit; i + 1 < used_n; i++) begin
			used_addr[i] = used_addr[i + 1];
			used_cls[i] = used_cls[i + 1];
		end
		used_n--;
		return g;
	endfunction

	// Send one word; hold valid until the block takes it, then queue its prediction
	task automatic send_word(input logic c, input logic [15:0] sz, input logic [15:0] ad);
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.request_size <= sz;
		req_ch.chunk_address <= ad;
		do @(posedge clk); while (!req_ch.ready);
		pending_grants.insert(pending_grants.size(), apply_word(c, sz, ad));
	endtask

	// Ignored fields carry random bits
	task automatic alloc_word(input logic [15:0] sz);
		send_word(CMD_ALLOC, sz, 16'($urandom));
	endtask

	task automatic free_word(input logic [15:0] ad);
		send_word(CMD_DEALLOC, 16'($urandom), ad);
	endtask

	// Drop valid and hold off until every expected word has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_grants.size() != 0);
	endtask

	// Write heap_limit only once the block is idle
	task automatic write_heap_limit(input int v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= HEAP_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_limit = v & 32'h1FFFF;
	endtask

	// Compare one result word with the oldest prediction
	always @(posedge clk) begin
		grant_t want;
		grant_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = '{rsp_ch.block_address, rsp_ch.block_size, rsp_ch.reused, rsp_ch.status};
			if (pending_grants.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected result word: addr %h size %0d reused %b status %0d",
						got.block_address, got.block_size, got.reused, got.status);
			end else begin
				want = pending_grants.pop_front();
				if (got.block_address !== want.block_address
						|| got.block_size !== want.block_size
						|| got.reused !== want.reused || got.status !== want.status) begin
					error_count++;
					if (error_count <= 10) begin
						$display("Mismatch at cycle %0d: expected addr %h size %0d reused %b status %0d",
							cycle_count, want.block_address, want.block_size, want.reused,
							want.status);
						$display("    got addr %h size %0d reused %b status %0d",
							got.block_address, got.block_size, got.reused, got.status);
					end
				end
			end
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Mostly class edges and in-range sizes, some oversized words
	function automatic logic [15:0] pick_alloc_size();
		logic [15:0] sz;
		int c;
		int need;
		int top;
		int i;
		logic fits;
		if ($urandom_range(9) == 0)
			return 16'($urandom_range(513, 65535));
		c = $urandom_range(4);
		case ($urandom_range(3))
			0: sz = 16'(32 << c);
			1: sz = 16'((32 << c) + 1);
			2: sz = 16'((16 << c) + 1);
			default: sz = 16'($urandom_range(0, 512));
		endcase
		// Near the block cap, steer a word that would cut a new block onto a free one
		if (sz <= 16'd512 && used_n + free_n >= BLOCK_CAP && used_n < USED_ENTRIES) begin
			need = 0;
			while ((32 << need) < sz) need++;
			fits = 1'b0;
			top = 0;
			for (i = 0; i < free_n; i++) begin
				if (free_cls[i] >= need) fits = 1'b1;
				if (free_cls[i] > top) top = free_cls[i];
			end
			if (!fits) sz = 16'($urandom_range(0, 32 << top));
		end
		return sz;
	endfunction

	// Mostly blocks in use, some free blocks and random addresses
	function automatic logic [15:0] pick_release_addr();
		int r;
		r = $urandom_range(99);
		if (used_n > 0 && r < 85)
			return used_addr[$urandom_range(used_n - 1)];
		if (free_n > 0 && r < 92)
			return free_addr[$urandom_range(free_n - 1)];
		return 16'($urandom);
	endfunction

	// One block of every class and two oversized words; zero bytes rounds up, first bump block sits at zero
	task automatic test_size_classes();
		alloc_word(16'd0);
		alloc_word(16'd33);
		alloc_word(16'd100);
		alloc_word(16'd200);
		alloc_word(16'd512);
		alloc_word(16'd513);
		alloc_word(16'hFFFF);
	endtask

	// Release known blocks, an unknown address and a block already free
	task automatic test_release();
		free_word(16'hFFFF);
		free_word(16'd32);
		free_word(16'd480);
		free_word(16'd0);
		free_word(16'd32);
	endtask

	// Smallest fit wins over earlier larger blocks; equal classes go to the earliest freed
	task automatic test_best_fit();
		alloc_word(16'd40);
		alloc_word(16'd1);
		alloc_word(16'd129);
		alloc_word(16'd20);
		free_word(16'd992);
		free_word(16'd0);
		alloc_word(16'd7);
	endtask

	// Heap limit at zero, an exact fit at the limit, then the largest value
	task automatic test_heap_limit();
		write_heap_limit(0);
		alloc_word(16'd64);
		write_heap_limit(bump + 96);
		alloc_word(16'd64);
		alloc_word(16'd33);
		alloc_word(16'd32);
		alloc_word(16'd32);
		write_heap_limit(17'h1FFFF);
		alloc_word(16'd512);
	endtask

	// Bursts of allocations and releases, with mixed noise between them
	task automatic random_traffic(input int items, input int spct, input int rpct,
			input int limit);
		int sent;
		int kind;
		int len;
		int j;
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		write_heap_limit(limit);
		sent = 0;
		while (sent < items) begin
			kind = $urandom_range(9);
			len = $urandom_range(1, 20);
			for (j = 0; j < len && sent < items; j++) begin
				if (kind < 4 || (kind >= 8 && $urandom_range(1) == 0))
					alloc_word(pick_alloc_size());
				else
					free_word(pick_release_addr());
				sent++;
			end
			// Pause the sender now and then until the block has answered everything
			if ($urandom_range(19) == 0) drain_results();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 36;
		recv_idle_pct = 87;
		test_size_classes();
		test_release();
		test_best_fit();
		test_heap_limit();
		random_traffic(180, 36, 87, HEAP_SPAN);
		random_traffic(180, 36, 87, bump + $urandom_range(0, 3000));
		random_traffic(180, 87, 36, 17'h1FFFF);
		random_traffic(180, 87, 36, $urandom_range(0, 4096));
		random_traffic(180, 0, 0, 0);
		random_traffic(180, 0, 0, HEAP_SPAN);
		drain_results();
		// Let any stray word show up before the verdict
		repeat (40) @(posedge clk);
		if (error_count == 0 && pending_grants.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
